@@ rtl/mtg_pkg.sv @@
// Shared types and constants of the MT19937 generator.
`timescale 1ns / 1ps
package mtg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int FAR_WRAP     = STATE_WORDS - TWIST_OFFSET;
  localparam int ADDR_W       = $clog2(STATE_WORDS);
  localparam int WORD_W       = 32;

  localparam logic [WORD_W-1:0] MAT_A     = 32'h9908b0df;
  localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;
  localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C  = 32'hefc60000;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_TW_PRIME,
    ST_TW_RUN,
    ST_TW_DRAIN,
    ST_DRAW
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } ram_req_t;

  typedef struct packed {
    logic take;
    logic zero;
  } out_ctl_t;

endpackage

@@ rtl/mtg_ram.sv @@
// Generic single-write, dual-read synchronous RAM with registered reads.
`timescale 1ns / 1ps
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ rtl/mtg_core.sv @@
// Sequencer for reseed, twist and draw over the state memory.
`timescale 1ns / 1ps
module mtg_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   req_type,
  input  logic [31:0]                            seed,
  input  logic [mtg_pkg::WORD_W-1:0]             rdata_a,
  input  logic [mtg_pkg::WORD_W-1:0]             rdata_b,
  output logic                                   busy,
  output mtg_pkg::ram_req_t                      ram_req,
  output mtg_pkg::out_ctl_t                      out_ctl
);
  import mtg_pkg::*;

  state_t            state, state_next;
  logic [ADDR_W-1:0] idx;
  logic [WORD_W-1:0] prev;
  logic [WORD_W-1:0] cur;
  logic              s1_valid;
  logic [ADDR_W-1:0] s1_k;
  logic [ADDR_W-1:0] words_left;
  logic [ADDR_W-1:0] read_position;
  logic              seeded;

  logic [ADDR_W-1:0] draw_addr;
  logic [ADDR_W-1:0] nxt_addr;
  logic [ADDR_W-1:0] far_addr;
  logic [WORD_W-1:0] prev_mix;
  logic [WORD_W-1:0] seed_word;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] tw_word;

  assign busy      = (state != ST_IDLE);
  assign draw_addr = (read_position >= ADDR_W'(STATE_WORDS)) ? '0 : read_position;
  assign nxt_addr  = (idx == LAST_ADDR) ? '0 : idx + 1'b1;
  assign far_addr  = (idx < ADDR_W'(FAR_WRAP)) ? idx + ADDR_W'(TWIST_OFFSET)
                                               : idx - ADDR_W'(FAR_WRAP);
  assign prev_mix  = prev ^ (prev >> 30);
  assign seed_word = WORD_W'(prev_mix * SEED_MULT) + {{(WORD_W-ADDR_W){1'b0}}, idx};
  assign mix       = {cur[WORD_W-1], rdata_a[WORD_W-2:0]};
  assign tw_word   = rdata_b ^ (mix >> 1) ^ (rdata_a[0] ? MAT_A : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    ram_req.we      = 1'b0;
    ram_req.waddr   = idx;
    ram_req.wdata   = seed_word;
    ram_req.raddr_a = '0;
    ram_req.raddr_b = '0;
    out_ctl.take    = 1'b0;
    out_ctl.zero    = 1'b0;
    if (s1_valid) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = s1_k;
      ram_req.wdata = tw_word;
    end
    unique case (state)
      ST_IDLE: begin
        ram_req.raddr_a = draw_addr;
        if (start) begin
          if (!req_type) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = '0;
            ram_req.wdata = seed;
            state_next    = ST_SEED;
          end else if (!seeded) begin
            out_ctl.zero = 1'b1;
          end else if (words_left <= ADDR_W'(1)) begin
            state_next = ST_TW_PRIME;
          end else begin
            state_next = ST_DRAW;
          end
        end
      end
      ST_SEED: begin
        ram_req.we = 1'b1;
        if (idx == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_TW_PRIME: begin
        state_next = ST_TW_RUN;
      end
      ST_TW_RUN: begin
        ram_req.raddr_a = nxt_addr;
        ram_req.raddr_b = far_addr;
        if (idx == LAST_ADDR) begin
          state_next = ST_TW_DRAIN;
        end
      end
      ST_TW_DRAIN: begin
        state_next = ST_DRAW;
      end
      ST_DRAW: begin
        out_ctl.take = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      words_left    <= ADDR_W'(1);
      read_position <= '0;
      seeded        <= 1'b0;
      idx           <= '0;
    end else begin
      s1_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (!req_type) begin
              prev       <= seed;
              idx        <= ADDR_W'(1);
              words_left <= ADDR_W'(1);
              seeded     <= 1'b1;
            end else if (seeded) begin
              if (words_left <= ADDR_W'(1)) begin
                words_left <= ADDR_W'(STATE_WORDS);
                idx        <= '0;
              end else begin
                words_left    <= words_left - 1'b1;
                read_position <= draw_addr + 1'b1;
              end
            end
          end
        end
        ST_SEED: begin
          prev <= seed_word;
          idx  <= idx + 1'b1;
        end
        ST_TW_RUN: begin
          cur      <= rdata_a;
          s1_valid <= 1'b1;
          s1_k     <= idx;
          idx      <= idx + 1'b1;
        end
        ST_TW_DRAIN: begin
          read_position <= ADDR_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/mersenne_twister_generator_top.sv @@
// Top level of the MT19937 generator: state memory, sequencer, tempering output stage.
//
//  channel   ports                          direction  transfer
//  request   start, busy, req_type, seed     in         start high while busy low
//  result    result_valid, random_word       out        result_valid high, one cycle
//
//  A reseed keeps busy high after the transfer while it fills words 1 to 623, and gives no result.
//  A draw passes its word through the memory read and output registers, busy high for one cycle.
//  A draw that uses up the state first twists all 624 words, one per cycle through
//  the two read ports of the state memory, in the prime, run and drain states.
//  Before the first reseed a draw does not read the state and returns zero next cycle.
//  Reset leaves the block idle and unseeded; the receiver cannot stall results.
`timescale 1ns / 1ps
module mersenne_twister_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [31:0] seed,
  output logic        result_valid,
  output logic [31:0] random_word
);
  import mtg_pkg::*;

  ram_req_t          ram_req;
  out_ctl_t          out_ctl;
  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
    logic [WORD_W-1:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  mtg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STATE_WORDS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_req.we),
    .waddr   (ram_req.waddr),
    .wdata   (ram_req.wdata),
    .raddr_a (ram_req.raddr_a),
    .raddr_b (ram_req.raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  mtg_core u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .seed     (seed),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b),
    .busy     (busy),
    .ram_req  (ram_req),
    .out_ctl  (out_ctl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= out_ctl.take | out_ctl.zero;
    end
    if (out_ctl.zero) begin
      random_word <= '0;
    end else begin
      random_word <= temper(rdata_a);
    end
  end

endmodule

@@ bench/mtg_tb_pkg.sv @@
// Request codes shared by the MT19937 generator testbench and its checker.
`timescale 1ns / 1ps
package mtg_tb_pkg;

  typedef enum logic {
    REQ_RESEED = 1'b0,
    REQ_DRAW   = 1'b1
  } req_kind_t;

endpackage

@@ bench/mtg_checker.sv @@
// Checker for the MT19937 generator: tracks the twister state and compares every drawn word.
`timescale 1ns / 1ps
module mtg_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        req_type,
  input  logic [31:0] seed,
  input  logic        result_valid,
  input  logic [31:0] random_word,
  output int unsigned mismatches,
  output int unsigned words_owed
);
  import mtg_pkg::*;
  import mtg_tb_pkg::*;

  logic [WORD_W-1:0] twister [STATE_WORDS];
  logic [9:0]        draws_until_twist;
  logic [9:0]        read_ptr;
  logic [WORD_W-1:0] owed_words[$];

  initial begin
    mismatches = 0;
    words_owed = 0;
  end

  task automatic clear_twister();
    int i;
    begin
      for (i = 0; i < STATE_WORDS; i++) twister[i] = '0;
      draws_until_twist = 10'd1;
      read_ptr = '0;
    end
  endtask

  task automatic fill_from_seed(input logic [WORD_W-1:0] s);
    int j;
    logic [WORD_W-1:0] prev;
    begin
      twister[0] = s;
      for (j = 1; j < STATE_WORDS; j++) begin
        prev = twister[j-1];
        twister[j] = SEED_MULT * (prev ^ (prev >> 30)) + WORD_W'(j);
      end
    end
  endtask

  task automatic twist_in_place();
    int k;
    logic [WORD_W-1:0] cur, nxt, far, mix;
    begin
      for (k = 0; k < STATE_WORDS; k++) begin
        cur = twister[k];
        nxt = twister[(k + 1) % STATE_WORDS];
        far = twister[(k + TWIST_OFFSET) % STATE_WORDS];
        mix = {cur[WORD_W-1], nxt[WORD_W-2:0]};
        twister[k] = far ^ (mix >> 1) ^ (nxt[0] ? MAT_A : '0);
      end
    end
  endtask

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    begin
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
    end
  endfunction

  task automatic draw_next_word();
    logic [WORD_W-1:0] y;
    begin
      if (draws_until_twist <= 10'd1) begin
        twist_in_place();
        draws_until_twist = 10'(STATE_WORDS);
        read_ptr = '0;
      end else begin
        draws_until_twist = draws_until_twist - 10'd1;
      end
      if (read_ptr >= 10'(STATE_WORDS)) read_ptr = '0;
      y = twister[read_ptr];
      read_ptr = read_ptr + 10'd1;
      owed_words.push_back(temper(y));
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    begin
      $display("%0t mtg_checker: %s: got %08h, want %08h", $realtime, what, got, want);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_twister();
      owed_words.delete();
    end else begin
      if (result_valid) begin
        if (owed_words.size() == 0) begin
          report_mismatch("word with no draw outstanding", random_word, '0);
        end else begin
          if (random_word !== owed_words[0])
            report_mismatch("random_word", random_word, owed_words[0]);
          void'(owed_words.pop_front());
        end
      end
      if (start && !busy) begin
        if (req_type == REQ_DRAW) begin
          draw_next_word();
        end else begin
          fill_from_seed(seed);
          draws_until_twist = 10'd1;
        end
      end
    end
    words_owed <= owed_words.size();
  end

endmodule

@@ bench/tb_mersenne_twister_generator_top.sv @@
// Testbench top for the MT19937 generator: reset, request stimulus, timeout and verdict.
`timescale 1ns / 1ps
module tb_mersenne_twister_generator_top;
  import mtg_pkg::*;
  import mtg_tb_pkg::*;

  localparam int unsigned ITEM_TOTAL  = 1600;
  localparam int unsigned TAIL_ITEMS  = 150;
  localparam int unsigned TAIL_CYCLES = 700;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type = REQ_RESEED;
  logic [31:0] seed = '0;
  logic        result_valid;
  logic [31:0] random_word;

  int unsigned mismatches;
  int unsigned words_owed;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;

  always #6 clk = ~clk;

  mersenne_twister_generator_top u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .seed         (seed),
    .result_valid (result_valid),
    .random_word  (random_word)
  );

  mtg_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .seed         (seed),
    .result_valid (result_valid),
    .random_word  (random_word),
    .mismatches   (mismatches),
    .words_owed   (words_owed)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_mersenne_twister_generator_top: done, errors");
      $finish;
    end
  end

  task automatic issue(input req_kind_t kind, input logic [31:0] value);
    int unsigned gap;
    begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 17);
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      start    <= 1'b1;
      req_type <= kind;
      seed     <= value;
      @(posedge clk);
      while (busy) @(posedge clk);
      @(negedge clk);
      items_sent++;
    end
  endtask

  task automatic drain_words();
    begin
      start <= 1'b0;
      @(negedge clk);
      while (words_owed != 0) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned run_len;
    int unsigned n;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // unseeded state: draws give zero
    issue(REQ_DRAW, 32'h0000_0000);
    issue(REQ_DRAW, 32'hffff_ffff);
    issue(REQ_DRAW, $urandom);
    issue(REQ_RESEED, 32'd5489);
    issue(REQ_DRAW, 32'hffff_ffff);
    issue(REQ_DRAW, 32'h0000_0000);
    issue(REQ_DRAW, $urandom);
    issue(REQ_RESEED, 32'h0000_0000);
    issue(REQ_DRAW, $urandom);
    issue(REQ_DRAW, $urandom);
    issue(REQ_RESEED, 32'hffff_ffff);
    issue(REQ_DRAW, $urandom);
    issue(REQ_DRAW, $urandom);
    issue(REQ_RESEED, 32'h8000_0000);
    issue(REQ_DRAW, $urandom);
    issue(REQ_RESEED, 32'h0000_0001);
    issue(REQ_DRAW, $urandom);
    // reseed back to back, then reseed in the middle of a run
    issue(REQ_RESEED, 32'h7fff_ffff);
    issue(REQ_RESEED, 32'h1234_5678);
    issue(REQ_DRAW, $urandom);
    issue(REQ_DRAW, $urandom);
    issue(REQ_RESEED, 32'hdead_beef);
    issue(REQ_DRAW, $urandom);

    drain_words();

    while (items_sent < ITEM_TOTAL) begin
      idle_on = (items_sent + TAIL_ITEMS < ITEM_TOTAL) && ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 3) != 0) issue(REQ_RESEED, pick_seed());
      if ($urandom_range(0, 9) != 0) begin
        run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(625, 700)
                                               : $urandom_range(1, 30);
        for (n = 0; n < run_len && items_sent < ITEM_TOTAL; n++) begin
          if (items_sent + TAIL_ITEMS >= ITEM_TOTAL) idle_on = 1'b0;
          issue(REQ_DRAW, $urandom);
        end
      end
      if (idle_on && $urandom_range(0, 7) == 0) drain_words();
    end

    drain_words();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("tb_mersenne_twister_generator_top: done, clean");
    end else begin
      $display("tb_mersenne_twister_generator_top: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mtg_pkg.sv
rtl/mtg_ram.sv
rtl/mtg_core.sv
rtl/mersenne_twister_generator_top.sv
bench/mtg_tb_pkg.sv
bench/mtg_checker.sv
bench/tb_mersenne_twister_generator_top.sv
